>>> rtl/core/multilevel_queue_slot_scheduler_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multilevel queue slot scheduler
// Clocked on clk_i; the plain form is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_QUEUE_SLOT_SCHEDULER_UNIT_ASSERT_SVH
`define MULTILEVEL_QUEUE_SLOT_SCHEDULER_UNIT_ASSERT_SVH

// check outside reset
`define MLQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// check at every edge, reset included
`define MLQS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

>>> rtl/core/mlqs_pkg.sv
// ----------------------------------------------------------------------------
// mlqs_pkg
// Command and status codes and the request and result words of the
// multilevel queue slot scheduler.
// ----------------------------------------------------------------------------
package mlqs_pkg;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_GET = 1'b1
  } mlqs_cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DROP = 2'd1,
    ST_NONE = 2'd2
  } mlqs_status_e;

  typedef struct packed {
    mlqs_cmd_e   command;
    logic [3:0]  level;
    logic [7:0]  proc_id;
  } mlqs_in_t;

  typedef struct packed {
    logic         granted;
    logic [7:0]   granted_id;
    logic [3:0]   granted_level;
    mlqs_status_e status;
  } mlqs_out_t;

endpackage

>>> rtl/core/mlqs_meta_mem.sv
// ----------------------------------------------------------------------------
// mlqs_meta_mem
// Per-level FIFO head and count, one write and one registered read a cycle.
// A valid bit per entry makes a never-written level read as empty.
// ----------------------------------------------------------------------------
module mlqs_meta_mem #(
  parameter int DEPTH = 16,
  parameter int HW    = 4,
  parameter int CW    = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [HW-1:0]            rd_head_o,
  output logic [CW-1:0]            rd_count_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [HW-1:0]            wr_head_i,
  input  logic [CW-1:0]            wr_count_i
);

  logic [HW+CW-1:0] mem [DEPTH];
  logic [HW+CW-1:0] rdata_q;
  logic [DEPTH-1:0] vld_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_head_i, wr_count_i};
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // unwritten level reads as head zero, count zero
  assign rd_head_o  = rvld_q ? rdata_q[HW+CW-1:CW] : '0;
  assign rd_count_o = rvld_q ? rdata_q[CW-1:0]     : '0;

endmodule

>>> rtl/core/mlqs_store_mem.sv
// ----------------------------------------------------------------------------
// mlqs_store_mem
// Handle storage for all level FIFOs, one write and one registered read.
// ----------------------------------------------------------------------------
module mlqs_store_mem #(
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [7:0]               rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [7:0]               wr_data_i
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

>>> rtl/core/multilevel_queue_slot_scheduler_unit.sv
// ----------------------------------------------------------------------------
// multilevel_queue_slot_scheduler_unit
// Multilevel ready queue with a slot budget per level, served round robin.
// ----------------------------------------------------------------------------
// One command at a time: a word is taken when start is high and busy is low,
// and its result word appears on res_o for one cycle with res_valid_o high;
// the receiver cannot hold it off. An enqueue keeps busy high while it reads
// the level's head and count, and its result is registered from that read.
// A get served at the current level keeps busy high through the head/count
// read and then the handle read; when the current level is empty or its
// budget is spent, a scan over the nonempty flags first looks at up to LEVELS
// levels in turn, the last being the start level itself, and a get that finds
// nothing returns its result when the scan reaches the start level again.
// There is no clearing pass after reset: per-level valid bits make every
// FIFO read as empty until it is first written.
// ----------------------------------------------------------------------------
module multilevel_queue_slot_scheduler_unit
  import mlqs_pkg::*;
#(
  parameter int LEVELS      = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  mlqs_in_t  req_i,
  output logic      res_valid_o,
  output mlqs_out_t res_o
);

  localparam int LW = $clog2(LEVELS);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int BW = $clog2(LEVELS + 1);
  localparam int SD = LEVELS * QUEUE_DEPTH;
  localparam int AW = $clog2(SD);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_SCAN,
    S_GMETA,
    S_GDATA
  } state_e;

  state_e           state_q, state_d;
  mlqs_in_t         req_q, req_d;
  logic [LW-1:0]    cur_lvl_q, cur_lvl_d;
  logic [BW-1:0]    cur_budget_q, cur_budget_d;
  logic [LW-1:0]    tgt_q, tgt_d;
  logic [LW-1:0]    scan_lvl_q, scan_lvl_d;
  logic [LEVELS-1:0] nonempty_q, nonempty_d;
  logic             res_valid_q, res_valid_d;
  mlqs_out_t        res_q, res_d;

  logic             meta_rd_en;
  logic [LW-1:0]    meta_rd_addr;
  logic [QW-1:0]    meta_rd_head;
  logic [CW-1:0]    meta_rd_count;
  logic             meta_wr_en;
  logic [LW-1:0]    meta_wr_addr;
  logic [QW-1:0]    meta_wr_head;
  logic [CW-1:0]    meta_wr_count;

  logic             st_rd_en;
  logic [AW-1:0]    st_rd_addr;
  logic [7:0]       st_rd_data;
  logic             st_wr_en;
  logic [AW-1:0]    st_wr_addr;

  logic [LW-1:0]    enq_lvl;
  logic             enq_lvl_ok;
  logic [QW:0]      enq_psum;
  logic [QW-1:0]    enq_pos;
  logic [QW-1:0]    head_next;

  function automatic logic [BW-1:0] full_budget(logic [LW-1:0] l);
    return BW'(LEVELS - 32'(l));
  endfunction

  function automatic logic [LW-1:0] next_level(logic [LW-1:0] l);
    return (32'(l) == LEVELS - 1) ? '0 : LW'(32'(l) + 1);
  endfunction

  mlqs_meta_mem #(
    .DEPTH (LEVELS),
    .HW    (QW),
    .CW    (CW)
  ) u_meta (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (meta_rd_en),
    .rd_addr_i  (meta_rd_addr),
    .rd_head_o  (meta_rd_head),
    .rd_count_o (meta_rd_count),
    .wr_en_i    (meta_wr_en),
    .wr_addr_i  (meta_wr_addr),
    .wr_head_i  (meta_wr_head),
    .wr_count_i (meta_wr_count)
  );

  mlqs_store_mem #(
    .DEPTH (SD)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (st_rd_addr),
    .rd_data_o (st_rd_data),
    .wr_en_i   (st_wr_en),
    .wr_addr_i (st_wr_addr),
    .wr_data_i (req_q.proc_id)
  );

  assign enq_lvl    = LW'(req_q.level);
  assign enq_lvl_ok = (32'(req_q.level) < LEVELS);
  assign enq_psum   = {1'b0, meta_rd_head} + (QW+1)'(meta_rd_count);
  assign enq_pos    = (32'(enq_psum) >= QUEUE_DEPTH) ?
                      QW'(32'(enq_psum) - QUEUE_DEPTH) : QW'(enq_psum);
  assign head_next  = (32'(meta_rd_head) == QUEUE_DEPTH - 1) ? '0 :
                      QW'(32'(meta_rd_head) + 1);

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    cur_lvl_d    = cur_lvl_q;
    cur_budget_d = cur_budget_q;
    tgt_d        = tgt_q;
    scan_lvl_d   = scan_lvl_q;
    nonempty_d   = nonempty_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;

    meta_rd_en    = 1'b0;
    meta_rd_addr  = '0;
    meta_wr_en    = 1'b0;
    meta_wr_addr  = '0;
    meta_wr_head  = '0;
    meta_wr_count = '0;
    st_rd_en      = 1'b0;
    st_rd_addr    = '0;
    st_wr_en      = 1'b0;
    st_wr_addr    = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d = req_i;
          if (req_i.command == CMD_ENQ) begin
            meta_rd_en   = 1'b1;
            meta_rd_addr = LW'(req_i.level);
            state_d      = S_ENQ;
          end else if (nonempty_q[cur_lvl_q] && (cur_budget_q != '0)) begin
            tgt_d        = cur_lvl_q;
            meta_rd_en   = 1'b1;
            meta_rd_addr = cur_lvl_q;
            state_d      = S_GMETA;
          end else begin
            // leave the current level and look at the others in turn
            scan_lvl_d = next_level(cur_lvl_q);
            state_d    = S_SCAN;
          end
        end
      end

      S_ENQ: begin
        res_valid_d         = 1'b1;
        res_d.granted       = 1'b0;
        res_d.granted_id    = '0;
        res_d.granted_level = '0;
        if (!enq_lvl_ok || (32'(meta_rd_count) == QUEUE_DEPTH)) begin
          res_d.status = ST_DROP;
        end else begin
          st_wr_en            = 1'b1;
          st_wr_addr          = AW'(32'(enq_lvl) * QUEUE_DEPTH + 32'(enq_pos));
          meta_wr_en          = 1'b1;
          meta_wr_addr        = enq_lvl;
          meta_wr_head        = meta_rd_head;
          meta_wr_count       = CW'(32'(meta_rd_count) + 1);
          nonempty_d[enq_lvl] = 1'b1;
          res_d.status        = ST_OK;
        end
        state_d = S_IDLE;
      end

      S_SCAN: begin
        if (nonempty_q[scan_lvl_q]) begin
          // a level the pointer did not stay on holds its full budget
          tgt_d        = scan_lvl_q;
          cur_lvl_d    = scan_lvl_q;
          cur_budget_d = full_budget(scan_lvl_q);
          meta_rd_en   = 1'b1;
          meta_rd_addr = scan_lvl_q;
          state_d      = S_GMETA;
        end else if (scan_lvl_q == cur_lvl_q) begin
          // pointer wrapped back to its start; restore its budget
          cur_budget_d        = full_budget(cur_lvl_q);
          res_valid_d         = 1'b1;
          res_d.granted       = 1'b0;
          res_d.granted_id    = '0;
          res_d.granted_level = '0;
          res_d.status        = ST_NONE;
          state_d             = S_IDLE;
        end else begin
          scan_lvl_d = next_level(scan_lvl_q);
        end
      end

      S_GMETA: begin
        st_rd_en          = 1'b1;
        st_rd_addr        = AW'(32'(tgt_q) * QUEUE_DEPTH + 32'(meta_rd_head));
        meta_wr_en        = 1'b1;
        meta_wr_addr      = tgt_q;
        meta_wr_head      = head_next;
        meta_wr_count     = CW'(32'(meta_rd_count) - 1);
        nonempty_d[tgt_q] = (32'(meta_rd_count) != 1);
        cur_budget_d      = BW'(32'(cur_budget_q) - 1);
        state_d           = S_GDATA;
      end

      S_GDATA: begin
        res_valid_d         = 1'b1;
        res_d.granted       = 1'b1;
        res_d.granted_id    = st_rd_data;
        res_d.granted_level = 4'(tgt_q);
        res_d.status        = ST_OK;
        state_d             = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_lvl_q    <= '0;
      cur_budget_q <= BW'(LEVELS);
      nonempty_q   <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_lvl_q    <= cur_lvl_d;
      cur_budget_q <= cur_budget_d;
      nonempty_q   <= nonempty_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    tgt_q      <= tgt_d;
    scan_lvl_q <= scan_lvl_d;
    res_q      <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`include "multilevel_queue_slot_scheduler_unit_assert.svh"

  `MLQS_ASSERT(a_res_pulse, res_valid_q |=> !res_valid_q, "result strobe held two cycles")
  `MLQS_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
  `MLQS_ASSERT(a_grant_count, (state_q == S_GMETA) |-> (meta_rd_count != '0), "grant from empty FIFO")
  `MLQS_ASSERT_ALWAYS(a_budget_bound, (!rst_ni || ((32'(cur_budget_q) + 32'(cur_lvl_q)) <= LEVELS)), "budget above full value")

endmodule
